[rtl/afd_pkg.sv]
`default_nettype none

package afd_pkg;

    localparam int FRAC_BITS = 14;
    localparam int MAX_BANDS = 512;

    localparam int SAMPLE_W = 16;
    localparam int DEPTH_W  = 15;
    localparam int AREA_W   = 24;
    localparam int LEN_W    = 10;
    localparam int CNT_W    = 9;
    localparam int NB_W     = 10;
    localparam int CFG_W    = 15;

    localparam int REC_DATA_W = DEPTH_W + AREA_W + LEN_W + CNT_W;
    localparam int TDATA_W    = ((REC_DATA_W + 7) / 8) * 8;

    localparam logic [DEPTH_W-1:0] ONE_FX   = DEPTH_W'(1 << FRAC_BITS);
    localparam logic [AREA_W-1:0]  AREA_MAX = '1;
    localparam logic [LEN_W-1:0]   LEN_MAX  = '1;
    localparam logic [CNT_W-1:0]   CNT_MAX  = '1;

    localparam logic [NB_W-1:0] BAND_COUNT_MIN   = NB_W'(3);
    localparam logic [NB_W-1:0] BAND_COUNT_RESET = NB_W'(512);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef enum logic
    {
        REG_DEPTH_THR  = 1'b0,
        REG_BAND_COUNT = 1'b1
    } cfg_reg_t;

    localparam logic KIND_FEATURE = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed
    {
        logic [DEPTH_W-1:0] depth;
        logic               deep;
        logic               final_band;
    } item_t;

    typedef struct packed
    {
        logic               kind;
        logic [DEPTH_W-1:0] peak;
        logic [AREA_W-1:0]  area;
        logic [LEN_W-1:0]   width;
        logic [CNT_W-1:0]   count;
        logic               last;
    } record_t;

endpackage

`default_nettype wire

[rtl/afd_front.sv]
`default_nettype none

module afd_front #(
    parameter int MAX_BANDS = afd_pkg::MAX_BANDS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic                              cfg_index,
    input  wire logic [afd_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic                              accept,
    input  wire logic [afd_pkg::SAMPLE_W-1:0]      sample,
    output afd_pkg::item_t                         item
);

    localparam int NB_MAX = (MAX_BANDS > 1023) ? 1023 : MAX_BANDS;
    localparam int IDX_W  = $clog2(NB_MAX);

    logic [afd_pkg::DEPTH_W-1:0] depth_thr_reg;
    logic [afd_pkg::NB_W-1:0]    band_count_reg;
    logic [IDX_W-1:0]            band_index_reg;
    logic [IDX_W-1:0]            band_index_next;

    logic [afd_pkg::DEPTH_W-1:0] thr;
    logic [afd_pkg::NB_W-1:0]    nb;
    logic                        below_one;
    logic                        final_band;
    logic [afd_pkg::DEPTH_W-1:0] depth;

    always_comb
    begin
        thr = (depth_thr_reg > afd_pkg::ONE_FX) ? afd_pkg::ONE_FX : depth_thr_reg;

        if (band_count_reg < afd_pkg::BAND_COUNT_MIN)
        begin
            nb = afd_pkg::BAND_COUNT_MIN;
        end
        else if (band_count_reg > afd_pkg::NB_W'(NB_MAX))
        begin
            nb = afd_pkg::NB_W'(NB_MAX);
        end
        else
        begin
            nb = band_count_reg;
        end

        // index past a lowered band count also closes the spectrum
        final_band = afd_pkg::NB_W'(band_index_reg) >= (nb - afd_pkg::NB_W'(1));

        below_one = sample < afd_pkg::SAMPLE_W'(afd_pkg::ONE_FX);
        depth     = below_one ? (afd_pkg::ONE_FX - sample[afd_pkg::DEPTH_W-1:0]) : '0;

        item.depth      = depth;
        item.deep       = below_one && (depth > thr);
        item.final_band = final_band;

        band_index_next = final_band ? '0 : band_index_reg + IDX_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_thr_reg  <= '0;
            band_count_reg <= afd_pkg::BAND_COUNT_RESET;
            band_index_reg <= '0;
        end
        else
        begin
            if (cfg_write && (cfg_index == afd_pkg::REG_DEPTH_THR))
            begin
                depth_thr_reg <= cfg_data[afd_pkg::DEPTH_W-1:0];
            end
            if (cfg_write && (cfg_index == afd_pkg::REG_BAND_COUNT))
            begin
                band_count_reg <= cfg_data[afd_pkg::NB_W-1:0];
            end
            if (accept)
            begin
                band_index_reg <= band_index_next;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/afd_fifo.sv]
`default_nettype none

module afd_fifo (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  afd_pkg::item_t push_item,
    output logic           full,
    input  wire logic      pop,
    output logic           head_valid,
    output afd_pkg::item_t head_item
);

    afd_pkg::item_t                  mem [afd_pkg::QDEPTH];
    logic [afd_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [afd_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [afd_pkg::QPTR_W:0]        count_reg;
    logic [afd_pkg::QPTR_W:0]        count_next;

    assign full       = count_reg == (afd_pkg::QPTR_W+1)'(afd_pkg::QDEPTH);
    assign head_valid = count_reg != '0;
    assign head_item  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (afd_pkg::QPTR_W+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (afd_pkg::QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + afd_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + afd_pkg::QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/afd_back.sv]
`default_nettype none

module afd_back (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_valid,
    input  afd_pkg::item_t  q_item,
    output logic            pop,
    input  wire logic       out_ready,
    output logic            out_valid,
    output afd_pkg::record_t out_rec
);

    function automatic afd_pkg::record_t make_rec(
        input logic                        kind,
        input logic [afd_pkg::DEPTH_W-1:0] peak,
        input logic [afd_pkg::AREA_W-1:0]  area,
        input logic [afd_pkg::LEN_W-1:0]   width,
        input logic [afd_pkg::CNT_W-1:0]   count,
        input logic                        last
    );
        afd_pkg::record_t r;
        r.kind  = kind;
        r.peak  = peak;
        r.area  = area;
        r.width = width;
        r.count = count;
        r.last  = last;
        return r;
    endfunction

    logic                        in_run_reg,   in_run_next;
    logic [afd_pkg::DEPTH_W-1:0] run_peak_reg, run_peak_next;
    logic [afd_pkg::AREA_W-1:0]  run_area_reg, run_area_next;
    logic [afd_pkg::LEN_W-1:0]   run_len_reg,  run_len_next;
    logic [afd_pkg::CNT_W-1:0]   found_reg,    found_next;

    logic                        out_valid_reg,  out_valid_next;
    afd_pkg::record_t            out_rec_reg,    out_rec_next;
    logic                        pend_valid_reg, pend_valid_next;
    afd_pkg::record_t            pend_rec_reg,   pend_rec_next;

    logic [afd_pkg::DEPTH_W-1:0] add_peak;
    logic [afd_pkg::AREA_W:0]    area_sum;
    logic [afd_pkg::AREA_W-1:0]  add_area;
    logic [afd_pkg::LEN_W-1:0]   add_len;
    logic [afd_pkg::CNT_W-1:0]   found_inc;
    logic [afd_pkg::CNT_W-1:0]   found_fin;

    afd_pkg::record_t            rec_a;
    afd_pkg::record_t            rec_b;
    logic [1:0]                  n_rec;
    logic                        slot_free;

    // one band folded into the open run
    always_comb
    begin
        add_peak  = (q_item.depth > run_peak_reg) ? q_item.depth : run_peak_reg;
        area_sum  = {1'b0, run_area_reg} + (afd_pkg::AREA_W+1)'(q_item.depth);
        add_area  = area_sum[afd_pkg::AREA_W] ? afd_pkg::AREA_MAX
                                              : area_sum[afd_pkg::AREA_W-1:0];
        add_len   = (run_len_reg == afd_pkg::LEN_MAX) ? run_len_reg
                                                      : run_len_reg + afd_pkg::LEN_W'(1);
        found_inc = (found_reg == afd_pkg::CNT_MAX) ? found_reg
                                                    : found_reg + afd_pkg::CNT_W'(1);
    end

    always_comb
    begin
        in_run_next   = in_run_reg;
        run_peak_next = run_peak_reg;
        run_area_next = run_area_reg;
        run_len_next  = run_len_reg;
        found_next    = found_reg;
        found_fin     = found_reg;
        rec_a         = '0;
        rec_b         = '0;
        n_rec         = 2'd0;

        if (!q_item.final_band)
        begin
            if (q_item.deep)
            begin
                if (!in_run_reg)
                begin
                    in_run_next = 1'b1;
                    found_next  = found_inc;
                end
                run_peak_next = add_peak;
                run_area_next = add_area;
                run_len_next  = add_len;
            end
            else if (in_run_reg)
            begin
                rec_a = make_rec(afd_pkg::KIND_FEATURE, run_peak_reg, run_area_reg,
                                 run_len_reg, '0, 1'b1);
                n_rec = 2'd1;
                in_run_next   = 1'b0;
                run_peak_next = '0;
                run_area_next = '0;
                run_len_next  = '0;
            end
        end
        else
        begin
            if (q_item.deep && !in_run_reg)
            begin
                // run opened on the final band: counted, reported empty
                found_fin = found_inc;
                rec_a     = make_rec(afd_pkg::KIND_FEATURE, '0, '0, '0, '0, 1'b0);
                n_rec     = 2'd2;
            end
            else if (in_run_reg)
            begin
                if (q_item.deep)
                begin
                    rec_a = make_rec(afd_pkg::KIND_FEATURE, add_peak, add_area,
                                     add_len, '0, 1'b0);
                end
                else
                begin
                    rec_a = make_rec(afd_pkg::KIND_FEATURE, run_peak_reg, run_area_reg,
                                     run_len_reg, '0, 1'b0);
                end
                n_rec = 2'd2;
            end
            else
            begin
                n_rec = 2'd1;
            end

            if (n_rec == 2'd2)
            begin
                rec_b = make_rec(afd_pkg::KIND_SUMMARY, '0, '0, '0, found_fin, 1'b1);
            end
            else
            begin
                rec_a = make_rec(afd_pkg::KIND_SUMMARY, '0, '0, '0, found_fin, 1'b1);
            end

            in_run_next   = 1'b0;
            run_peak_next = '0;
            run_area_next = '0;
            run_len_next  = '0;
            found_next    = '0;
        end
    end

    assign slot_free = !out_valid_reg || out_ready;
    assign pop       = q_valid && ((n_rec == 2'd0) || (slot_free && !pend_valid_reg));

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_rec_next    = out_rec_reg;
        pend_valid_next = pend_valid_reg;
        pend_rec_next   = pend_rec_reg;

        if (slot_free)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_rec_next    = pend_rec_reg;
                pend_valid_next = 1'b0;
            end
            else if (pop && (n_rec != 2'd0))
            begin
                out_valid_next  = 1'b1;
                out_rec_next    = rec_a;
                pend_valid_next = n_rec == 2'd2;
                pend_rec_next   = rec_b;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_rec_reg  <= out_rec_next;
        pend_rec_reg <= pend_rec_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_run_reg     <= 1'b0;
            run_peak_reg   <= '0;
            run_area_reg   <= '0;
            run_len_reg    <= '0;
            found_reg      <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                in_run_reg   <= in_run_next;
                run_peak_reg <= run_peak_next;
                run_area_reg <= run_area_next;
                run_len_reg  <= run_len_next;
                found_reg    <= found_next;
            end
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_rec   = out_rec_reg;

endmodule

`default_nettype wire

[rtl/absorption_feature_detector_core.sv]
// A band passes through the queue to the back end, which registers the record it closes in the output stage.
// Throughput: one band per cycle while the output stage and its pending slot can take records.
// A final band that closes a feature yields two records; the second waits in a pending slot
// and holds the back end, and the four-entry queue between front and back end absorbs it.
// Reset (rst_n low, asynchronous) empties the queue and output stage, clears all run state,
// sets the depth threshold to 0 and band_count to 512.
`default_nettype none

module absorption_feature_detector_core #(
    parameter int MAX_BANDS = afd_pkg::MAX_BANDS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [afd_pkg::SAMPLE_W-1:0]     s_tdata,   // sample

    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [afd_pkg::TDATA_W-1:0]           m_tdata,   // peak_depth, area, width,
                                                             // feature_count, zero pad
    output logic                                  m_tlast,
    output logic [0:0]                            m_tuser,   // record_kind

    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic                             cfg_index,
    input  wire logic [afd_pkg::CFG_W-1:0]        cfg_data
);

    afd_pkg::item_t   front_item;
    afd_pkg::item_t   head_item;
    afd_pkg::record_t rec;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    logic             s_accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign s_accept  = s_tvalid && s_tready;

    afd_front #(
        .MAX_BANDS (MAX_BANDS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (s_accept),
        .sample    (s_tdata),
        .item      (front_item)
    );

    afd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s_accept),
        .push_item  (front_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (head_item)
    );

    afd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (head_item),
        .pop       (q_pop),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_rec   (rec)
    );

    assign m_tdata = {(afd_pkg::TDATA_W - afd_pkg::REC_DATA_W)'(0),
                      rec.count, rec.width, rec.area, rec.peak};
    assign m_tlast = rec.last;
    assign m_tuser = rec.kind;

    a_summary_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser[0] == afd_pkg::KIND_SUMMARY)) |-> m_tlast)
        else $error("summary record without tlast");

    a_summary_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser[0] == afd_pkg::KIND_SUMMARY))
            |-> (rec.peak == '0 && rec.area == '0 && rec.width == '0))
        else $error("summary record carries feature fields");

    a_feature_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser[0] == afd_pkg::KIND_FEATURE)) |-> (rec.count == '0))
        else $error("feature record carries a count");

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

endmodule

`default_nettype wire

[test/absorption_feature_detector_core_tb.sv]
`default_nettype none

module absorption_feature_detector_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import afd_pkg::*;

    localparam int UNITY            = 1 << FRAC_BITS;
    localparam int SETTLE_CYCLES    = 10;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int RANDOM_PER_PHASE = 170;
    localparam int MAX_PRINTS       = 40;

    // m_tdata field positions, lowest first
    localparam int AREA_LSB  = DEPTH_W;
    localparam int WIDTH_LSB = AREA_LSB + AREA_W;
    localparam int COUNT_LSB = WIDTH_LSB + LEN_W;
    localparam int PAD_LSB   = COUNT_LSB + CNT_W;

    logic                clk;
    logic                rst_n;

    logic                s_tvalid;
    logic                s_tready;
    logic [SAMPLE_W-1:0] s_tdata;

    logic                m_tvalid;
    logic                m_tready;
    logic [TDATA_W-1:0]  m_tdata;
    logic                m_tlast;
    logic [0:0]          m_tuser;

    logic                cfg_valid;
    logic                cfg_ready;
    logic                cfg_index;
    logic [CFG_W-1:0]    cfg_data;

    // register copies and detector state, as the block holds them
    logic [CFG_W-1:0]    depth_thr_q  = '0;
    logic [NB_W-1:0]     band_count_q = BAND_COUNT_RESET;
    logic [8:0]          band_pos     = '0;
    logic                run_open     = 1'b0;
    logic [DEPTH_W-1:0]  feat_peak    = '0;
    logic [AREA_W-1:0]   feat_area    = '0;
    logic [LEN_W-1:0]    feat_len     = '0;
    logic [CNT_W-1:0]    feat_total   = '0;

    record_t             expected_records[$];

    int                  err_count      = 0;
    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;

    // band pattern generator: alternating deep and shallow stretches
    logic                gen_deep = 1'b0;
    int                  gen_left = 0;

    absorption_feature_detector_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("** absorption_feature_detector_core: FAILED **");
        $finish;
    end

    function automatic int eff_threshold();
        return (int'(depth_thr_q) > UNITY) ? UNITY : int'(depth_thr_q);
    endfunction

    function automatic int eff_band_count();
        int nb;
        nb = int'(band_count_q);
        if (nb < int'(BAND_COUNT_MIN))
            nb = int'(BAND_COUNT_MIN);
        if (nb > MAX_BANDS)
            nb = MAX_BANDS;
        return nb;
    endfunction

    function automatic void push_record(input logic kind, input int peak, input int area,
                                        input int len, input int count, input logic last);
        record_t rec;
        rec.kind  = kind;
        rec.peak  = DEPTH_W'(peak);
        rec.area  = AREA_W'(area);
        rec.width = LEN_W'(len);
        rec.count = CNT_W'(count);
        rec.last  = last;
        expected_records.push_back(rec);
    endfunction

    function automatic void grow_feature(input int depth);
        if (depth > int'(feat_peak))
            feat_peak = DEPTH_W'(depth);
        if (int'(feat_area) + depth > int'(AREA_MAX))
            feat_area = AREA_MAX;
        else
            feat_area = AREA_W'(int'(feat_area) + depth);
        if (feat_len != LEN_MAX)
            feat_len++;
    endfunction

    function automatic void clear_feature();
        run_open  = 1'b0;
        feat_peak = '0;
        feat_area = '0;
        feat_len  = '0;
    endfunction

    // Expected records for one accepted band.
    function automatic void predict_band(input logic [SAMPLE_W-1:0] smp);
        int   thr;
        int   depth;
        logic deep;
        logic last_band;
        thr       = eff_threshold();
        last_band = int'(band_pos) >= eff_band_count() - 1;
        depth     = (int'(smp) < UNITY) ? UNITY - int'(smp) : 0;
        deep      = (int'(smp) < UNITY) && (depth > thr);

        if (!last_band)
        begin
            if (deep)
            begin
                if (!run_open)
                begin
                    run_open = 1'b1;
                    if (feat_total != CNT_MAX)
                        feat_total++;
                end
                grow_feature(depth);
            end
            else if (run_open)
            begin
                push_record(KIND_FEATURE, feat_peak, feat_area, feat_len, 0, 1'b1);
                clear_feature();
            end
            band_pos++;
        end
        else
        begin
            // a feature opening on the final band is counted but carries nothing
            if (deep && !run_open)
            begin
                if (feat_total != CNT_MAX)
                    feat_total++;
                push_record(KIND_FEATURE, 0, 0, 0, 0, 1'b0);
            end
            else if (run_open)
            begin
                if (deep)
                    grow_feature(depth);
                push_record(KIND_FEATURE, feat_peak, feat_area, feat_len, 0, 1'b0);
            end
            push_record(KIND_SUMMARY, 0, 0, 0, feat_total, 1'b1);
            clear_feature();
            feat_total = '0;
            band_pos   = '0;
        end
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("%0t ns: %s mismatch: expected %0d, got %0d", $time, what, want, got);
    endtask

    // Record checker; also drives m_tready.
    initial
    begin
        record_t want;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (expected_records.size() == 0)
                    report_mismatch("unexpected record", 0, 1);
                else
                begin
                    want = expected_records.pop_front();
                    if (m_tuser[0] !== want.kind)
                        report_mismatch("record_kind", want.kind, m_tuser[0]);
                    if (m_tdata[AREA_LSB-1:0] !== want.peak)
                        report_mismatch("peak_depth", want.peak, m_tdata[AREA_LSB-1:0]);
                    if (m_tdata[WIDTH_LSB-1:AREA_LSB] !== want.area)
                        report_mismatch("area", want.area, m_tdata[WIDTH_LSB-1:AREA_LSB]);
                    if (m_tdata[COUNT_LSB-1:WIDTH_LSB] !== want.width)
                        report_mismatch("width", want.width, m_tdata[COUNT_LSB-1:WIDTH_LSB]);
                    if (m_tdata[PAD_LSB-1:COUNT_LSB] !== want.count)
                        report_mismatch("feature_count", want.count,
                                        m_tdata[PAD_LSB-1:COUNT_LSB]);
                    if (m_tlast !== want.last)
                        report_mismatch("last", want.last, m_tlast);
                    if (m_tdata[TDATA_W-1:PAD_LSB] !== '0)
                        report_mismatch("tdata pad", 0, m_tdata[TDATA_W-1:PAD_LSB]);
                end
            end
            m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_band(input logic [SAMPLE_W-1:0] smp);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_band(smp);
    endtask

    // Drop valid, let every expected record drain, then allow bands still
    // in flight that close nothing to pass through.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_records.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_DEPTH_THR)
            depth_thr_q = val;
        else
            band_count_q = val[NB_W-1:0];
    endtask

    function automatic logic [SAMPLE_W-1:0] next_sample();
        int thr;
        int pick;
        thr = eff_threshold();
        if (gen_left == 0)
        begin
            gen_deep = !gen_deep;
            gen_left = gen_deep ? $urandom_range(8, 1) : $urandom_range(4, 1);
        end
        gen_left--;
        pick = $urandom_range(99);
        if (pick < 8)
            return SAMPLE_W'($urandom_range(65535, 0));
        // right at the threshold, or one step deeper
        if (pick < 14)
            return SAMPLE_W'((pick[0] || thr == UNITY) ? UNITY - thr : UNITY - thr - 1);
        if (gen_deep && thr < UNITY)
            return SAMPLE_W'($urandom_range(UNITY - thr - 1, 0));
        if (pick < 57)
            return SAMPLE_W'($urandom_range(UNITY, UNITY - thr));
        return SAMPLE_W'($urandom_range(65535, UNITY));
    endfunction

    task automatic send_bands(input int n);
        repeat (n) send_band(next_sample());
    endtask

    // Reset values: zero threshold, full-length spectrum.
    task automatic test_default_spectrum();
        send_bands(eff_band_count());
    endtask

    task automatic test_feature_edges();
        write_reg(REG_BAND_COUNT, CFG_W'(3));
        write_reg(REG_DEPTH_THR, '0);
        // deepest band, closed by the largest sample, final band exactly at one
        send_band('0);
        send_band('1);
        send_band(SAMPLE_W'(UNITY));
        // feature opening on the final band
        send_band(SAMPLE_W'(UNITY + 1));
        send_band(SAMPLE_W'(20000));
        send_band(SAMPLE_W'(UNITY - 1));
        // feature running through the final band
        send_band(SAMPLE_W'(1));
        send_band(SAMPLE_W'(2));
        send_band(SAMPLE_W'(3));

        // depth equal to the threshold is not deep, one more is
        write_reg(REG_DEPTH_THR, CFG_W'(1000));
        send_band(SAMPLE_W'(UNITY - 1000));
        send_band(SAMPLE_W'(UNITY - 1001));
        send_band('1);

        // threshold at one and above one: nothing can be deep
        write_reg(REG_DEPTH_THR, CFG_W'(UNITY));
        send_band('0);
        send_band('0);
        send_band('0);
        write_reg(REG_DEPTH_THR, '1);
        send_band('0);
        send_band(SAMPLE_W'(1));
        send_band('0);
    endtask

    task automatic test_band_count_limits();
        write_reg(REG_DEPTH_THR, '0);
        write_reg(REG_BAND_COUNT, '0);
        send_band('0);
        send_band(SAMPLE_W'(20000));
        send_band('0);
        write_reg(REG_BAND_COUNT, CFG_W'(2));
        send_band(SAMPLE_W'(20000));
        send_band('0);
        send_band('0);
    endtask

    // Shrink the spectrum under an open feature: the next band becomes final.
    task automatic test_lowered_band_count();
        write_reg(REG_BAND_COUNT, CFG_W'(1023));
        repeat (5) send_band('0);
        write_reg(REG_BAND_COUNT, CFG_W'(4));
        send_band('0);
    endtask

    task automatic test_random_traffic();
        int phase;
        int sent;
        int seg;
        int nb;
        int pick;
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            sent = 0;
            while (sent < RANDOM_PER_PHASE)
            begin
                if ($urandom_range(1))
                begin
                    pick = $urandom_range(99);
                    if (pick < 20)
                        write_reg(REG_DEPTH_THR, '0);
                    else if (pick < 50)
                        write_reg(REG_DEPTH_THR, CFG_W'($urandom_range(2000, 1)));
                    else if (pick < 80)
                        write_reg(REG_DEPTH_THR, CFG_W'($urandom_range(16000, 2000)));
                    else if (pick < 90)
                        write_reg(REG_DEPTH_THR, CFG_W'(UNITY));
                    else
                        write_reg(REG_DEPTH_THR, CFG_W'($urandom_range(32767, UNITY + 1)));
                end
                if ($urandom_range(1))
                begin
                    pick = $urandom_range(99);
                    // upper bits of the write data fall outside the register
                    if (pick < 70)
                        nb = $urandom_range(24, 3);
                    else if (pick < 88)
                        nb = $urandom_range(100, 25);
                    else if (pick < 93)
                        nb = $urandom_range(2, 0);
                    else if (pick < 98)
                        nb = $urandom_range(200, 101);
                    else
                        nb = $urandom_range(1023, 513);
                    write_reg(REG_BAND_COUNT,
                              CFG_W'(($urandom_range(31) << NB_W) | nb));
                end
                nb = eff_band_count();
                if (nb <= 200 && $urandom_range(99) < 80)
                    seg = nb - int'(band_pos);
                else
                    seg = $urandom_range(40, 1);
                if (seg < 1)
                    seg = 1;
                send_bands(seg);
                sent += seg;
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_DEPTH_THR;
        cfg_data  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_spectrum();
        test_feature_edges();
        test_band_count_limits();
        test_lowered_band_count();
        test_random_traffic();

        wait_idle();
        if (err_count == 0)
            $display("** absorption_feature_detector_core: PASSED **");
        else
            $display("** absorption_feature_detector_core: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
